/* rtl/core/kct_pkg.sv */
`timescale 1ns / 1ps
package kct_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_WIDTH   = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int TAG_W       = 16;
    localparam int AMT_W       = 32;
    localparam int COUNT_W     = 31;
    localparam int STATUS_W    = 3;
    localparam int ENTRY_W     = KEY_WIDTH + COUNT_W;

    localparam int IN_FIELDS_W  = 1 + TAG_W + AMT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = COUNT_W + STATUS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [STATUS_W-1:0]  t_status;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam t_status ST_UPDATED  = 3'd0;
    localparam t_status ST_INSERTED = 3'd1;
    localparam t_status ST_FREED    = 3'd2;
    localparam t_status ST_IGNORED  = 3'd3;
    localparam t_status ST_FULL     = 3'd4;

    typedef struct packed {
        logic capture;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

/* rtl/core/keyed_count_table_unit.sv */
`timescale 1ns / 1ps
// Keyed count table: holds up to TABLE_DEPTH key/count pairs in a single-port-write,
// registered-read RAM with valid flags in flip-flops (cleared by reset, no clearing pass).
// Each request takes its own tag, looks it up by scanning the table one entry a cycle
// and then adds to, inserts, decrements or frees the entry (or leaves the table as it is
// for an ignored or full request), returning one result with the count after the
// request and a status code. One request is handled at a time: a request is captured,
// scanned through the table RAM read port up to a hit or the last entry, and committed
// once the previous result has been taken.
module keyed_count_table_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // op [0], tag [16:1], amount [48:17], zero fill above
    input  logic [kct_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // count_after [30:0], status [33:31], zero fill above
    output logic [kct_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import kct_pkg::*;

    t_cmd    w_cmd;
    t_sts    w_sts;
    t_count  w_count;
    t_status w_status;

    kct_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    kct_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_op         (s_axis_tdata[0]),
        .i_tag        (s_axis_tdata[TAG_W:1]),
        .i_amount     (s_axis_tdata[TAG_W+AMT_W:TAG_W+1]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_count_after(w_count),
        .o_status     (w_status)
    );

    assign m_axis_tdata = OUT_TDATA_W'({w_status, w_count});

endmodule

/* rtl/core/kct_ram.sv */
`timescale 1ns / 1ps
module kct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/kct_ctrl.sv */
`timescale 1ns / 1ps
module kct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  kct_pkg::t_sts i_sts,
    output kct_pkg::t_cmd o_cmd
);
    import kct_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* rtl/core/kct_dpath.sv */
`timescale 1ns / 1ps
module kct_dpath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  kct_pkg::t_cmd            i_cmd,
    output kct_pkg::t_sts            o_sts,
    input  logic                     i_op,
    input  logic [kct_pkg::TAG_W-1:0] i_tag,
    input  logic [kct_pkg::AMT_W-1:0] i_amount,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output kct_pkg::t_count          o_count_after,
    output kct_pkg::t_status         o_status
);
    import kct_pkg::*;

    // captured request
    logic             r_op;
    t_key             r_key;
    logic [AMT_W-1:0] r_amt;

    // scan pipeline
    t_idx   r_rd_idx;
    logic   r_rd_on;
    t_idx   r_cmp_idx;
    logic   r_cmp_on;
    logic   r_hit;
    t_idx   r_slot;
    t_count r_cnt;
    logic   r_free_found;
    t_idx   r_free;

    logic [TABLE_DEPTH-1:0] r_valid;

    // result register
    logic    r_out_valid;
    t_count  r_out_count;
    t_status r_out_status;

    logic [ENTRY_W-1:0] w_rdata;
    t_key               w_rd_key;
    t_count             w_rd_cnt;
    logic               w_cmp_valid;
    logic               w_hit;
    logic               w_last;
    logic               w_done;

    logic               w_positive;
    t_count             w_amt;
    logic [COUNT_W:0]   w_sum;
    t_count             w_sat;
    t_count             w_diff;
    logic               w_we;
    t_idx               w_waddr;
    t_count             w_wcnt;
    logic               w_set_valid;
    logic               w_clr_valid;
    t_count             w_res_count;
    t_status            w_res_status;

    assign w_rd_key    = w_rdata[ENTRY_W-1:COUNT_W];
    assign w_rd_cnt    = w_rdata[COUNT_W-1:0];
    assign w_cmp_valid = r_valid[r_cmp_idx];
    assign w_hit       = i_cmd.scan && r_cmp_on && w_cmp_valid && (w_rd_key == r_key);
    assign w_last      = (r_cmp_idx == IDX_W'(TABLE_DEPTH - 1));
    assign w_done      = i_cmd.scan && r_cmp_on && (w_hit || w_last);

    assign o_sts.scan_done = w_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_on      <= 1'b0;
            r_cmp_on     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.capture) begin
            r_rd_on      <= 1'b1;
            r_cmp_on     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_on  <= r_rd_on && !w_done && (r_rd_idx != IDX_W'(TABLE_DEPTH - 1));
            r_cmp_on <= r_rd_on && !w_done;
            if (w_hit) begin
                r_hit <= 1'b1;
            end
            if (r_cmp_on && !w_cmp_valid && !r_free_found) begin
                r_free_found <= 1'b1;
            end
        end else begin
            r_rd_on  <= 1'b0;
            r_cmp_on <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_key    <= KEY_WIDTH'(i_tag);
            r_amt    <= i_amount;
            r_rd_idx <= '0;
        end else if (i_cmd.scan) begin
            r_rd_idx  <= r_rd_idx + IDX_W'(1);
            r_cmp_idx <= r_rd_idx;
            if (w_hit) begin
                r_slot <= r_cmp_idx;
                r_cnt  <= w_rd_cnt;
            end
            if (r_cmp_on && !w_cmp_valid && !r_free_found) begin
                r_free <= r_cmp_idx;
            end
        end
    end

    // update decision
    always_comb begin
        w_positive   = (r_amt != '0) && !r_amt[AMT_W-1];
        w_amt        = r_amt[COUNT_W-1:0];
        w_sum        = {1'b0, r_cnt} + {1'b0, w_amt};
        w_sat        = w_sum[COUNT_W] ? {COUNT_W{1'b1}} : w_sum[COUNT_W-1:0];
        w_diff       = r_cnt - w_amt;
        w_we         = 1'b0;
        w_waddr      = r_slot;
        w_wcnt       = w_sat;
        w_set_valid  = 1'b0;
        w_clr_valid  = 1'b0;
        w_res_count  = '0;
        w_res_status = ST_IGNORED;
        if (r_key == '0) begin
            w_res_status = ST_IGNORED;
        end else if (!w_positive) begin
            w_res_count = r_hit ? r_cnt : '0;
        end else if (r_op == OP_ADD) begin
            if (r_hit) begin
                w_we         = 1'b1;
                w_wcnt       = w_sat;
                w_res_count  = w_sat;
                w_res_status = ST_UPDATED;
            end else if (r_free_found) begin
                w_we         = 1'b1;
                w_waddr      = r_free;
                w_wcnt       = w_amt;
                w_set_valid  = 1'b1;
                w_res_count  = w_amt;
                w_res_status = ST_INSERTED;
            end else begin
                w_res_status = ST_FULL;
            end
        end else if (r_hit) begin
            if (r_cnt <= w_amt) begin
                w_clr_valid  = 1'b1;
                w_res_status = ST_FREED;
            end else begin
                w_we         = 1'b1;
                w_wcnt       = w_diff;
                w_res_count  = w_diff;
                w_res_status = ST_UPDATED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
            if (w_set_valid) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (w_clr_valid) begin
                r_valid[r_slot] <= 1'b0;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_count  <= w_res_count;
            r_out_status <= w_res_status;
        end
    end

    kct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(IDX_W)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (i_cmd.commit && w_we),
        .i_waddr(w_waddr),
        .i_wdata({r_key, w_wcnt}),
        .i_raddr(r_rd_idx),
        .o_rdata(w_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_count_after = r_out_count;
    assign o_status      = r_out_status;

endmodule

/* verif/keyed_count_table_unit_tb.sv */
`timescale 1ns / 1ps
module keyed_count_table_unit_tb;
    import kct_pkg::*;

    typedef struct packed {
        t_count  count;
        t_status status;
    } t_table_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // op, tag, amount, zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // count_after, status, zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    keyed_count_table_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow copy of the table
    t_key          slot_key   [TABLE_DEPTH];
    t_count        slot_count [TABLE_DEPTH];
    bit            slot_used  [TABLE_DEPTH];
    t_table_result pending_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int status_hits [5];
    logic [15:0] key_pool [48];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    function automatic t_table_result predict_request(input logic op, input logic [15:0] tag,
                                                      input logic [31:0] amount);
        t_table_result r;
        t_key          key;
        bit            positive;
        int            hit;
        int            free_slot;
        logic [31:0]   sum;
        key       = tag[KEY_WIDTH-1:0];
        positive  = (amount != 32'd0) && !amount[31];
        r.count   = '0;
        r.status  = ST_IGNORED;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_used[i] && slot_key[i] == key && hit < 0) hit = i;
            if (!slot_used[i] && free_slot < 0) free_slot = i;
        end
        if (key != '0) begin
            if (!positive) begin
                if (hit >= 0) r.count = slot_count[hit];
            end else if (op == OP_ADD) begin
                if (hit >= 0) begin
                    sum = {1'b0, slot_count[hit]} + amount;
                    if (sum > 32'h7FFF_FFFF) sum = 32'h7FFF_FFFF;
                    slot_count[hit] = sum[COUNT_W-1:0];
                    r.count  = sum[COUNT_W-1:0];
                    r.status = ST_UPDATED;
                end else if (free_slot >= 0) begin
                    slot_used[free_slot]  = 1'b1;
                    slot_key[free_slot]   = key;
                    slot_count[free_slot] = amount[COUNT_W-1:0];
                    r.count  = amount[COUNT_W-1:0];
                    r.status = ST_INSERTED;
                end else begin
                    r.status = ST_FULL;
                end
            end else if (hit >= 0) begin
                if ({1'b0, slot_count[hit]} <= amount) begin
                    slot_used[hit] = 1'b0;
                    r.status = ST_FREED;
                end else begin
                    slot_count[hit] = slot_count[hit] - amount[COUNT_W-1:0];
                    r.count  = slot_count[hit];
                    r.status = ST_UPDATED;
                end
            end
        end
        return r;
    endfunction

    function automatic int used_slots();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) if (slot_used[i]) n++;
        return n;
    endfunction

    task automatic send_request(input logic op, input logic [15:0] tag, input logic [31:0] amount);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({amount, tag, op});
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_request(op, tag, amount));
        requests_sent++;
    endtask

    // hold off until every result is back, then let the block settle
    task automatic drain_results();
        int waited;
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $display("error: %0d results never arrived", pending_results.size());
            error_count += pending_results.size();
            pending_results.delete();
        end
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_table_result want;
        t_count        got_count;
        t_status       got_status;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_count  = m_axis_tdata[COUNT_W-1:0];
            got_status = m_axis_tdata[COUNT_W +: STATUS_W];
            results_seen++;
            if (got_status < 5) status_hits[got_status]++;
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("error: unexpected transfer count=%0d status=%0d",
                             got_count, got_status);
            end else begin
                want = pending_results.pop_front();
                if (got_count !== want.count || got_status !== want.status) begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"error: result %0d expected count=%0d status=%0d,",
                                  " got count=%0d status=%0d"},
                                 results_seen, want.count, want.status,
                                 got_count, got_status);
                end
            end
        end
    end

    task automatic test_basic_ops();
        send_request(OP_ADD,    16'h0001, 32'd1);
        send_request(OP_ADD,    16'h0001, 32'd5);
        send_request(OP_REMOVE, 16'h0001, 32'd2);
        send_request(OP_REMOVE, 16'h0001, 32'd4);
        send_request(OP_REMOVE, 16'h0001, 32'd1);
        send_request(OP_ADD,    16'hFFFF, 32'h7FFF_FFFF);
        send_request(OP_ADD,    16'hFFFF, 32'd1);
        send_request(OP_REMOVE, 16'hFFFF, 32'h7FFF_FFFF);
        send_request(OP_ADD,    16'h8000, 32'd10);
        send_request(OP_REMOVE, 16'h8000, 32'd1000);
        drain_results();
    endtask

    task automatic test_ignored_requests();
        send_request(OP_ADD,    16'h0000, 32'd5);
        send_request(OP_REMOVE, 16'h0000, 32'd5);
        send_request(OP_ADD,    16'h0007, 32'd0);
        send_request(OP_ADD,    16'h0007, 32'd3);
        send_request(OP_ADD,    16'h0007, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 16'h0007, 32'h8000_0000);
        send_request(OP_REMOVE, 16'h0007, 32'd0);
        send_request(OP_REMOVE, 16'h5555, 32'd9);
        drain_results();
    endtask

    task automatic test_slot_reuse();
        send_request(OP_ADD,    16'h0A0A, 32'd4);
        send_request(OP_ADD,    16'h0B0B, 32'd6);
        send_request(OP_REMOVE, 16'h0A0A, 32'd4);
        send_request(OP_ADD,    16'h0C0C, 32'd8);
        send_request(OP_ADD,    16'h0B0B, 32'd1);
        send_request(OP_REMOVE, 16'h0C0C, 32'd3);
        send_request(OP_REMOVE, 16'h0B0B, 32'h7FFF_FFFF);
        send_request(OP_REMOVE, 16'h0C0C, 32'd5);
        send_request(OP_REMOVE, 16'h0007, 32'd3);
        drain_results();
    endtask

    task automatic test_table_full();
        int n;
        n = 0;
        while (used_slots() < TABLE_DEPTH && n < 2 * TABLE_DEPTH) begin
            send_request(OP_ADD, 16'hA000 + n[15:0], n + 1);
            n++;
        end
        send_request(OP_ADD,    16'hBEEF, 32'd9);
        send_request(OP_REMOVE, 16'hBEEF, 32'd1);
        send_request(OP_REMOVE, 16'hA003, 32'h7FFF_FFFF);
        send_request(OP_ADD,    16'hBEEF, 32'd9);
        send_request(OP_ADD,    16'hA003, 32'd2);
        for (int i = 0; i < n; i++) send_request(OP_REMOVE, 16'hA000 + i[15:0], 32'h7FFF_FFFF);
        send_request(OP_REMOVE, 16'hBEEF, 32'd9);
        drain_results();
    endtask

    task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
        int          pool_size;
        int          pick;
        logic        op;
        logic [15:0] tag;
        logic [31:0] amount;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < 48; i++) key_pool[i] = 16'($urandom_range(65535, 1));
        pool_size = 10;
        for (int k = 0; k < items; k++) begin
            // switch at random between a few hot keys and more keys than the table holds
            if (k % 60 == 0) pool_size = $urandom_range(1) ? 10 : 48;
            pick = $urandom_range(99);
            if (pick < 4)       tag = 16'h0000;
            else if (pick < 10) tag = 16'($urandom_range(65535));
            else                tag = key_pool[$urandom_range(pool_size - 1)];
            pick = $urandom_range(99);
            if (pick < 4)       amount = 32'd0;
            else if (pick < 9)  amount = $urandom() | 32'h8000_0000;
            else if (pick < 14) amount = $urandom();
            else if (pick < 19) amount = 32'h7FFF_FFFF - $urandom_range(1000);
            else                amount = $urandom_range(300, 1);
            op = ($urandom_range(99) < 55) ? OP_ADD : OP_REMOVE;
            send_request(op, tag, amount);
        end
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_ignored_requests();
        test_slot_reuse();
        test_table_full();
        test_random_traffic(362, 0, 0);
        test_random_traffic(362, 72, 0);
        test_random_traffic(363, 0, 72);
        test_random_traffic(363, 36, 36);
        $display("covered %0d requests, %0d results, %0d entries left in the table",
                 requests_sent, results_seen, used_slots());
        $display("status mix: updated %0d, inserted %0d, freed %0d, ignored %0d, full %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d errors", error_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
